// File: rtl/core/skt_pkg.sv
// skt_pkg: command and status codes and the transfer payload types of the sorted key table
// no dependencies; imported by sorted_key_table

package skt_pkg;

   // command codes (any code with bit 1 set acts as a lookup)
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_PRESENT = 2'd1;
   localparam logic [1:0] ST_ABSENT  = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   // request transfer payload
   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] key;
   } req_type;

   // response transfer payload
   typedef struct packed {
      logic [1:0] status;
      logic [3:0] position;
      logic [4:0] entry_count;
   } rsp_type;

endpackage

// File: rtl/core/skt_key_ram.sv
// skt_key_ram: key store of the sorted key table, one write and one registered read per cycle
// no package dependencies; instantiated by sorted_key_table

module skt_key_ram #(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [KEY_BITS-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [KEY_BITS-1:0]        rd_data
);

   logic [KEY_BITS-1:0] key_store_ff [DEPTH];
   logic [KEY_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_store_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= key_store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/sorted_key_table.sv
// sorted_key_table: top level, sequencer for search, shift and response
// depends on skt_pkg and skt_key_ram
//
// Holds up to DEPTH unique keys in ascending order in a two-port key RAM.
// req channel: one command (insert, delete, lookup) per transfer; req_stall is
// low only while the sequencer is idle, so one command is worked at a time.
// rsp channel: exactly one result per command (status, position, entry count),
// held in an output register; a new command may be taken while it waits.
// Sequence: a binary search probe is a RAM read (S_PROBE), then a compare
// (S_CMP), and a miss is closed by one more S_PROBE. An insert then moves
// every larger key up one place and a delete moves them down, each moved key
// read (S_SH_RD), then written (S_SH_WR), and an insert then writes the new
// key (S_PUT). After S_DECIDE and any shift or write, S_RESP loads the
// response; the next command is taken in the cycle after it is loaded.
// Reset (synchronous, active high) empties the table and drops any pending
// response; the RAM contents are not cleared and need no clearing pass.
// While rsp_stall is high the response holds; a finished command waits for the
// output register to free before the sequencer returns to idle.

module sorted_key_table
   import skt_pkg::*;
#(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_PROBE  = 8'b0000_0010,
      S_CMP    = 8'b0000_0100,
      S_DECIDE = 8'b0000_1000,
      S_SH_RD  = 8'b0001_0000,
      S_SH_WR  = 8'b0010_0000,
      S_PUT    = 8'b0100_0000,
      S_RESP   = 8'b1000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       lo_ff, lo_in;
   logic [CW-1:0]       hi_ff, hi_in;
   logic [CW-1:0]       mid_ff, mid_in;
   logic [CW-1:0]       at_ff, at_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                found_ff, found_in;
   logic                up_ff, up_in;
   logic [1:0]          cmd_ff, cmd_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [1:0]          status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [KEY_BITS-1:0] wr_data;
   logic [AW-1:0]       rd_addr;
   logic [KEY_BITS-1:0] rd_data;
   logic [CW-1:0]       mid;
   logic [CW-1:0]       src;

   skt_key_ram #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // search midpoint and shift source
   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign src = up_ff ? (idx_ff - CW'(1)) : (idx_ff + CW'(1));

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      at_in        = at_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      up_in        = up_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = rd_data;
      rd_addr      = mid[AW-1:0];

      // response register drains independently
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data.cmd;
               key_in   = KEY_BITS'(req_data.key);
               lo_in    = '0;
               hi_in    = count_ff;
               found_in = 1'b0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid;
               state_in = S_CMP;
            end else begin
               at_in    = lo_ff;
               state_in = S_DECIDE;
            end
         end
         S_CMP: begin
            if (rd_data < key_ff) begin
               lo_in    = mid_ff + CW'(1);
               state_in = S_PROBE;
            end else if (rd_data > key_ff) begin
               hi_in    = mid_ff;
               state_in = S_PROBE;
            end else begin
               at_in    = mid_ff;
               found_in = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            status_in = ST_OK;
            state_in  = S_RESP;
            if (cmd_ff == CMD_INSERT) begin
               if (found_ff) begin
                  status_in = ST_PRESENT;
               end else if (count_ff >= CW'(DEPTH)) begin
                  status_in = ST_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
                  idx_in   = count_ff;
                  up_in    = 1'b1;
                  state_in = (count_ff > at_ff) ? S_SH_RD : S_PUT;
               end
            end else if (cmd_ff == CMD_DELETE) begin
               if (!found_ff) begin
                  status_in = ST_ABSENT;
               end else begin
                  count_in = count_ff - CW'(1);
                  idx_in   = at_ff;
                  up_in    = 1'b0;
                  if (at_ff < (count_ff - CW'(1))) begin
                     state_in = S_SH_RD;
                  end
               end
            end else begin
               if (!found_ff) begin
                  status_in = ST_ABSENT;
               end
            end
         end
         S_SH_RD: begin
            rd_addr  = src[AW-1:0];
            state_in = S_SH_WR;
         end
         S_SH_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data;
            idx_in  = src;
            if (up_ff) begin
               state_in = (src > at_ff) ? S_SH_RD : S_PUT;
            end else begin
               state_in = (src < count_ff) ? S_SH_RD : S_RESP;
            end
         end
         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = at_ff[AW-1:0];
            wr_data  = key_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = status_ff;
               rsp_data_in.position     = (status_ff == ST_OK) ? 4'(at_ff) : 4'd0;
               rsp_data_in.entry_count  = 5'(count_ff);
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      at_ff       <= at_in;
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      up_ff       <= up_in;
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: bench/tb_sorted_key_table.sv
// tb_sorted_key_table: self-checking bench for the sorted key table, predicts every
// result with a shadow copy of the table and checks each response in order
// depends on skt_pkg and sorted_key_table
`timescale 1ns / 100ps

module tb_sorted_key_table;
   import skt_pkg::*;

   localparam int DEPTH       = 16;
   localparam int KEY_BITS    = 16;
   localparam int POOL_SIZE   = 22;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_CMDS = 1125;

   // code 3 has bit 1 set, so the table treats it as a lookup
   localparam logic [1:0] CMD_LOOKUP_ALT = CMD_LOOKUP | CMD_DELETE;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} cmd_mix_type;

   // shadow table: predicts the response of every accepted command
   class key_table_scoreboard_type;
      logic [KEY_BITS-1:0] held_keys[DEPTH];
      int unsigned         held_count;
      rsp_type             expected_results[$];
      int unsigned         mismatch_count;

      function new();
         foreach (held_keys[i]) held_keys[i] = '0;
         held_count     = 0;
         mismatch_count = 0;
      endfunction

      function void note_command(req_type cmd_in);
         logic [KEY_BITS-1:0] k;
         int unsigned         lo;
         int unsigned         hi;
         int unsigned         mid;
         int unsigned         at;
         bit                  found;
         rsp_type             want;
         k     = cmd_in.key[KEY_BITS-1:0];
         lo    = 0;
         hi    = held_count;
         at    = 0;
         found = 1'b0;
         // binary search over the held keys
         while (lo < hi && !found) begin
            mid = lo + (hi - lo) / 2;
            if (held_keys[mid] < k) begin
               lo = mid + 1;
            end else if (held_keys[mid] > k) begin
               hi = mid;
            end else begin
               found = 1'b1;
               at    = mid;
            end
         end
         if (!found) at = lo;
         want.status   = ST_OK;
         want.position = '0;
         if (cmd_in.cmd[1]) begin
            // lookup
            if (found) want.position = at[3:0];
            else want.status = ST_ABSENT;
         end else if (cmd_in.cmd == CMD_INSERT) begin
            // duplicate check wins over the full check
            if (found) begin
               want.status = ST_PRESENT;
            end else if (held_count >= DEPTH) begin
               want.status = ST_FULL;
            end else begin
               for (int i = held_count; i > at; i--) held_keys[i] = held_keys[i-1];
               held_keys[at] = k;
               held_count++;
               want.position = at[3:0];
            end
         end else begin
            // delete closes the gap
            if (!found) begin
               want.status = ST_ABSENT;
            end else begin
               for (int i = at; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
               held_count--;
               want.position = at[3:0];
            end
         end
         want.entry_count = held_count[4:0];
         expected_results.push_back(want);
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatch_count++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            report_mismatch("response with no command outstanding");
         end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         got.status, want.status));
            if (got.position !== want.position)
               report_mismatch($sformatf("position got %0d want %0d",
                                         got.position, want.position));
            if (got.entry_count !== want.entry_count)
               report_mismatch($sformatf("entry_count got %0d want %0d",
                                         got.entry_count, want.entry_count));
         end
      endtask
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   key_table_scoreboard_type shadow_table = new();

   logic [KEY_BITS-1:0] key_pool[POOL_SIZE];
   bit                  holdoff_request = 1'b0;
   bit                  holdoff_done    = 1'b0;
   int unsigned         holdoff_left    = 0;
   int unsigned         stretch_left    = 0;
   int unsigned         stall_percent   = 0;
   int unsigned         cycle_count     = 0;

   sorted_key_table #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 2 ns clock
   always #1 clock = ~clock;

   // run length guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // response side: check each transfer, stall in random stretches plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) shadow_table.check_result(rsp_data);
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(8, 80);
            case ($urandom_range(0, 2))
               0:       stall_percent = 0;
               1:       stall_percent = 25;
               default: stall_percent = 75;
            endcase
         end else begin
            stretch_left--;
         end
         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_stall <= 1'b1;
         end else if (holdoff_request && !holdoff_done) begin
            holdoff_done = 1'b1;
            holdoff_left = $urandom_range(300, 500);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_percent);
         end
      end
   end

   function automatic req_type make_cmd(logic [1:0] code, logic [15:0] k);
      req_type c;
      c.cmd = code;
      c.key = k;
      return c;
   endfunction

   // offer one command and hold it until the transfer happens
   task automatic send_item(req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      shadow_table.note_command(item);
   endtask

   function automatic req_type random_command(cmd_mix_type mix);
      req_type     c;
      int unsigned roll;
      int unsigned ins_pct;
      int unsigned del_pct;
      case (mix)
         MIX_FILL:  begin ins_pct = 60; del_pct = 15; end
         MIX_DRAIN: begin ins_pct = 20; del_pct = 55; end
         default:   begin ins_pct = 35; del_pct = 35; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) c.cmd = CMD_INSERT;
      else if (roll < ins_pct + del_pct) c.cmd = CMD_DELETE;
      else c.cmd = $urandom_range(0, 1) ? CMD_LOOKUP : CMD_LOOKUP_ALT;
      // mostly keys from a small pool so hits and a full table are common
      if ($urandom_range(0, 99) < 85) c.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else c.key = 16'($urandom);
      return c;
   endfunction

   // extremes, every command, duplicates, absent keys, a full table
   task automatic run_directed();
      send_item(make_cmd(CMD_LOOKUP, 16'h1234));
      send_item(make_cmd(CMD_DELETE, 16'h1234));
      send_item(make_cmd(CMD_INSERT, 16'hffff));
      send_item(make_cmd(CMD_INSERT, 16'h0000));
      send_item(make_cmd(CMD_INSERT, 16'h8000));
      send_item(make_cmd(CMD_INSERT, 16'h8000));
      send_item(make_cmd(CMD_LOOKUP_ALT, 16'hffff));
      send_item(make_cmd(CMD_DELETE, 16'h8000));
      send_item(make_cmd(CMD_DELETE, 16'h8000));
      // fill from the top down so every insert shifts the larger keys
      for (int i = 14; i >= 1; i--) send_item(make_cmd(CMD_INSERT, 16'(i * 16'h1111)));
      send_item(make_cmd(CMD_INSERT, 16'h7777));
      send_item(make_cmd(CMD_INSERT, 16'h7778));
      send_item(make_cmd(CMD_DELETE, 16'h0000));
      send_item(make_cmd(CMD_LOOKUP_ALT, 16'hffff));
   endtask

   // random commands in bursts with gaps, changing mix and a slowly drifting key pool
   task automatic run_random(int unsigned count);
      int unsigned sent;
      int unsigned burst;
      int unsigned gap;
      cmd_mix_type mix;
      sent = 0;
      mix  = MIX_FILL;
      foreach (key_pool[i]) key_pool[i] = 16'($urandom);
      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hffff;
      while (sent < count) begin
         burst = $urandom_range(1, 16);
         for (int b = 0; b < burst && sent < count; b++) begin
            if (sent % 60 == 0) mix = cmd_mix_type'($urandom_range(0, 2));
            if (sent % 50 == 49) key_pool[$urandom_range(2, POOL_SIZE - 1)] = 16'($urandom);
            if (sent == count / 4) holdoff_request <= 1'b1;
            send_item(random_command(mix));
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) begin
               req_data <= req_type'(18'($urandom));
               @(posedge clock);
            end
         end
      end
   endtask

   // main sequence
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random(RANDOM_CMDS);
      req_valid <= 1'b0;
      while (shadow_table.expected_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (shadow_table.mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/skt_pkg.sv
rtl/core/skt_key_ram.sv
rtl/core/sorted_key_table.sv
bench/tb_sorted_key_table.sv
